// ----- src/svpwm_pkg.sv -----
// Shared constants and widths for the space-vector PWM duty pipeline.
// No dependencies.
`default_nettype none

package svpwm_pkg;

  // Pipeline depth from input transfer to output register
  localparam int STAGES = 8;

  // 1/sqrt3 at 30 fractional bits, split into two 15-bit halves
  localparam longint INV_SQRT3_Q30 = 64'd619925131;
  localparam int     KSPLIT        = 15;
  localparam logic [15:0] K_HI = 16'(INV_SQRT3_Q30 >> KSPLIT);
  localparam logic [15:0] K_LO = 16'(INV_SQRT3_Q30 & ((64'd1 << KSPLIT) - 64'd1));

  // Datapath widths
  localparam int PROD_W = 32;  // 16x16 signed product
  localparam int AB_W   = 33;  // alpha / beta at 30 fractional bits
  localparam int PP_W   = 49;  // alpha times one 15-bit half of the constant
  localparam int T_W    = 63;  // alpha * 1/sqrt3 at 60 fractional bits
  localparam int V_W    = 35;  // phase voltages at 30 fractional bits
  localparam int SUM_W  = 36;  // vmin + vmax
  localparam int D_W    = 38;  // unclamped duty at 31 fractional bits
  localparam int DUTY_W = 32;  // clamped duty, 0 .. 2^31
  localparam int MUL_W  = 48;  // duty * period

  localparam logic signed [D_W-1:0] HALF_Q31 = D_W'(64'sd1 <<< 30);
  localparam logic signed [D_W-1:0] ONE_Q31  = D_W'(64'sd1 <<< 31);

  // Phase to ignore for current sampling
  localparam logic [1:0] SKIP_A = 2'd0;
  localparam logic [1:0] SKIP_B = 2'd1;
  localparam logic [1:0] SKIP_C = 2'd2;

  localparam logic [15:0] PERIOD_RESET = 16'd1024;

endpackage

`default_nettype wire

// ----- src/space_vector_pwm_duty_core.sv -----
// Space-vector PWM duty generator: inverse Park/Clarke, min-max injection,
// clamp and period scaling in an eight-stage pipeline. Uses svpwm_pkg.
//
//   channel  | ports                                             | dir
//   ---------+---------------------------------------------------+-----
//   input    | in_valid/in_ready, in_volt_q/d, in_angle_sin/cos  | in
//   result   | out_valid/out_ready, out_compare_a/b/c, out_skip  | out
//   config   | cfg_wr_en, cfg_wr_data (timer period)             | in
//
// out_valid rises once an input item has reached the last stage; one item
// per cycle while out_ready is high, as a stalled output holds the flow.
// The stages in order: products, alpha/beta, split constant
// multiply, recombine, phase forming, min/max, clamp, period multiply.
// Each stage holds its item while the next stage is full and stalled, so
// bubbles collapse and a full pipe stalls only as far as needed.
// Reset (rst_n, synchronous) clears the valid bits and sets period to 1024.
`default_nettype none

module space_vector_pwm_duty_core
  import svpwm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_volt_q,
  input  wire logic signed [15:0] in_volt_d,
  input  wire logic signed [15:0] in_angle_sin,
  input  wire logic signed [15:0] in_angle_cos,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_compare_a,
  output logic [15:0]             out_compare_b,
  output logic [15:0]             out_compare_c,
  output logic [1:0]              out_skip_current,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data
);

  // ---------------------------------------------------------------------
  // Control: valid per stage, ready ripples back from the output
  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld_prev;

  always_comb begin
    rdy[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vld_prev = {vld_r[STAGES-2:0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_prev[i];
        end
      end
    end
  end

  // Period register
  logic [15:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: the four angle products
  logic signed [PROD_W-1:0] cd_r, sq_r, sd_r, cq_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cd_r <= in_angle_cos * in_volt_d;
      sq_r <= in_angle_sin * in_volt_q;
      sd_r <= in_angle_sin * in_volt_d;
      cq_r <= in_angle_cos * in_volt_q;
    end
  end

  // Stage 2: inverse Park
  logic signed [AB_W-1:0] alpha_r, beta2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      alpha_r <= AB_W'(cd_r) - AB_W'(sq_r);
      beta2_r <= AB_W'(sd_r) + AB_W'(cq_r);
    end
  end

  // Stage 3: alpha times each half of 1/sqrt3
  logic signed [PP_W-1:0] p_hi_r, p_lo_r;
  logic signed [AB_W-1:0] beta3_r;
  logic signed [16:0]     k_hi_s, k_lo_s;

  assign k_hi_s = $signed({1'b0, K_HI});
  assign k_lo_s = $signed({1'b0, K_LO});

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p_hi_r  <= alpha_r * k_hi_s;
      p_lo_r  <= alpha_r * k_lo_s;
      beta3_r <= beta2_r;
    end
  end

  // Stage 4: recombine the partial products
  logic signed [T_W-1:0]  t_r;
  logic signed [AB_W-1:0] beta4_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      t_r     <= (T_W'(p_hi_r) <<< KSPLIT) + T_W'(p_lo_r);
      beta4_r <= beta3_r;
    end
  end

  // Stage 5: scaled inverse Clarke, arithmetic shifts are floors
  logic signed [T_W-1:0] neg_t;
  logic signed [V_W-1:0] half_neg;
  logic signed [V_W-1:0] v1_nxt, v2_nxt, v3_nxt;
  logic signed [V_W-1:0] v1_r, v2_r, v3_r;

  always_comb begin
    neg_t    = -t_r;
    half_neg = V_W'(neg_t >>> 30);
    v1_nxt   = V_W'(t_r >>> 29);
    v2_nxt   = V_W'(beta4_r) + half_neg;
    v3_nxt   = half_neg - V_W'(beta4_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 6: min/max search and phase to skip
  logic signed [V_W-1:0]   vmin, vmax;
  logic [1:0]              skip_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [V_W-1:0]   v1b_r, v2b_r, v3b_r;
  logic [1:0]              skip6_r;

  always_comb begin
    if (v1_r > v2_r) begin
      vmin     = v2_r;
      vmax     = v1_r;
      skip_nxt = SKIP_A;
    end else begin
      vmin     = v1_r;
      vmax     = v2_r;
      skip_nxt = SKIP_B;
    end
    if (v3_r > vmax) begin
      vmax     = v3_r;
      skip_nxt = SKIP_C;
    end else if (v3_r < vmin) begin
      vmin = v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sum_r   <= SUM_W'(vmin) + SUM_W'(vmax);
      v1b_r   <= v1_r;
      v2b_r   <= v2_r;
      v3b_r   <= v3_r;
      skip6_r <= skip_nxt;
    end
  end

  // Stage 7: midpoint injection and clamp to 0..1
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [D_W-1:0] d);
    logic [DUTY_W-1:0] res;
    if (d < 0) begin
      res = '0;
    end else if (d > ONE_Q31) begin
      res = DUTY_W'(ONE_Q31);
    end else begin
      res = d[DUTY_W-1:0];
    end
    return res;
  endfunction

  logic signed [D_W-1:0]  shift_val;
  logic signed [D_W-1:0]  da, db, dc;
  logic [DUTY_W-1:0]      duty_a_r, duty_b_r, duty_c_r;
  logic [1:0]             skip7_r;

  always_comb begin
    shift_val = HALF_Q31 - D_W'(sum_r);
    da        = (D_W'(v1b_r) <<< 1) + shift_val;
    db        = (D_W'(v2b_r) <<< 1) + shift_val;
    dc        = (D_W'(v3b_r) <<< 1) + shift_val;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      duty_a_r <= clamp_duty(da);
      duty_b_r <= clamp_duty(db);
      duty_c_r <= clamp_duty(dc);
      skip7_r  <= skip6_r;
    end
  end

  // Stage 8: scale by period, keep integer part (product stays below 2^47)
  logic [MUL_W-1:0] mul_a, mul_b, mul_c;
  logic [15:0]      cmp_a_r, cmp_b_r, cmp_c_r;
  logic [1:0]       skip8_r;

  always_comb begin
    mul_a = MUL_W'(duty_a_r) * MUL_W'(period_r);
    mul_b = MUL_W'(duty_b_r) * MUL_W'(period_r);
    mul_c = MUL_W'(duty_c_r) * MUL_W'(period_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      cmp_a_r <= 16'(mul_a >> 31);
      cmp_b_r <= 16'(mul_b >> 31);
      cmp_c_r <= 16'(mul_c >> 31);
      skip8_r <= skip7_r;
    end
  end

  // Outputs
  assign out_valid        = vld_r[STAGES-1];
  assign out_compare_a    = cmp_a_r;
  assign out_compare_b    = cmp_b_r;
  assign out_compare_c    = cmp_c_r;
  assign out_skip_current = skip8_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb_space_vector_pwm_duty_core.sv -----
// Self-checking testbench for space_vector_pwm_duty_core: directed table plus random
// voltage/angle items, checked against an in-bench duty predictor.
// Depends on svpwm_pkg (latency, skip codes) and the core RTL only.
`default_nettype none

module tb_space_vector_pwm_duty_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint    RECIP_SQRT3_Q30 = 64'sd619925131;
  localparam longint    DUTY_HALF       = 64'sd1 <<< 30;
  localparam longint    DUTY_FULL       = 64'sd1 <<< 31;
  localparam int        IDLE_LIMIT      = 2000;
  localparam int        HOLD_CYCLES     = 100;
  localparam int        SETTLE_CYCLES   = svpwm_pkg::STAGES + 4;

  typedef struct packed {
    logic signed [15:0] vq;
    logic signed [15:0] vd;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
  } pwm_cmd_t;

  typedef struct packed {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic [1:0]  skip;
  } pwm_result_t;

  typedef struct packed {
    pwm_cmd_t    cmd;
    bit          typed;
    pwm_result_t res;
  } dir_row_t;

  localparam pwm_result_t NO_RES = '{16'd0, 16'd0, 16'd0, 2'd0};

  // Directed rows; typed results assume the reset period of 1024
  dir_row_t directed_rows [17] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'd512, 16'd512, 16'd512, svpwm_pkg::SKIP_B}},
    '{'{16'sd0, 16'sd0, 16'sd32767, -16'sd32768}, 1'b1,
      '{16'd512, 16'd512, 16'd512, svpwm_pkg::SKIP_B}},
    '{'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0}, 1'b1,
      '{16'd1024, 16'd0, 16'd0, svpwm_pkg::SKIP_A}},
    // phases two and three tie at the top
    '{'{16'sd32767, 16'sd0, 16'sd32767, 16'sd0}, 1'b1,
      '{16'd0, 16'd1024, 16'd1024, svpwm_pkg::SKIP_B}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, NO_RES},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, NO_RES},
    '{'{-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, NO_RES},
    '{'{16'sd0, 16'sd32767, 16'sd0, 16'sd32767}, 1'b0, NO_RES},
    '{'{16'sd0, -16'sd16384, 16'sd0, 16'sd32767}, 1'b0, NO_RES},
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, NO_RES},
    '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, NO_RES},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, NO_RES},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, NO_RES},
    '{'{16'sd8000, -16'sd3000, 16'sd23170, 16'sd23170}, 1'b0, NO_RES},
    '{'{16'sd32767, 16'sd32767, -16'sd23170, 16'sd23170}, 1'b0, NO_RES},
    '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, NO_RES},
    '{'{16'sd12345, -16'sd32768, -16'sd12000, 16'sd30000}, 1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_volt_q = '0;
  logic signed [15:0] in_volt_d = '0;
  logic signed [15:0] in_angle_sin = '0;
  logic signed [15:0] in_angle_cos = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_compare_a;
  logic [15:0]        out_compare_b;
  logic [15:0]        out_compare_c;
  logic [1:0]         out_skip_current;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;

  // Side band that travels with the payload: use the typed result instead
  bit                 use_typed = 1'b0;
  pwm_result_t        typed_result = NO_RES;

  logic [15:0]        period_model = 16'd1024;
  pwm_result_t        expected_duties [$];
  int                 mismatch_count = 0;
  int                 stall_cycles = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 hold_reqs = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  space_vector_pwm_duty_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_volt_q        (in_volt_q),
    .in_volt_d        (in_volt_d),
    .in_angle_sin     (in_angle_sin),
    .in_angle_cos     (in_angle_cos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_compare_a    (out_compare_a),
    .out_compare_b    (out_compare_b),
    .out_compare_c    (out_compare_c),
    .out_skip_current (out_skip_current),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Clamp a Q.31 duty to 0..1 and scale by the period
  function automatic logic [15:0] duty_to_compare(longint duty, logic [15:0] per);
    longint clamped;
    clamped = duty;
    if (clamped < 0) clamped = 0;
    if (clamped > DUTY_FULL) clamped = DUTY_FULL;
    return 16'((clamped * longint'(per)) >>> 31);
  endfunction

  // Inverse Park, scaled inverse Clarke, min-max injection, compare values
  function automatic pwm_result_t compute_duty(pwm_cmd_t cmd, logic [15:0] per);
    longint      alpha, beta, prod, half_neg, v1, v2, v3, vmin, vmax, offs;
    pwm_result_t res;
    alpha = longint'(cmd.cs) * longint'(cmd.vd) - longint'(cmd.sn) * longint'(cmd.vq);
    beta  = longint'(cmd.sn) * longint'(cmd.vd) + longint'(cmd.cs) * longint'(cmd.vq);
    prod     = alpha * RECIP_SQRT3_Q30;
    half_neg = (-prod) >>> 30;
    v1 = prod >>> 29;
    v2 = beta + half_neg;
    v3 = -beta + half_neg;
    // strict compares decide the skipped phase on ties
    if (v1 > v2) begin
      vmin = v2; vmax = v1; res.skip = svpwm_pkg::SKIP_A;
    end else begin
      vmin = v1; vmax = v2; res.skip = svpwm_pkg::SKIP_B;
    end
    if (v3 > vmax) begin
      vmax = v3; res.skip = svpwm_pkg::SKIP_C;
    end else if (v3 < vmin) begin
      vmin = v3;
    end
    offs = DUTY_HALF - (vmin + vmax);
    res.cmp_a = duty_to_compare(2 * v1 + offs, per);
    res.cmp_b = duty_to_compare(2 * v2 + offs, per);
    res.cmp_c = duty_to_compare(2 * v3 + offs, per);
    return res;
  endfunction

  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly rotating vectors of varied amplitude, some raw noise and corner values
  function automatic pwm_cmd_t random_cmd();
    pwm_cmd_t cmd;
    int       kind;
    real      ang;
    kind = $urandom_range(9);
    if (kind < 6) begin
      ang = $urandom_range(65535) * 6.283185307179586 / 65536.0;
      cmd.sn = 16'($rtoi(32767.0 * $sin(ang)));
      cmd.cs = 16'($rtoi(32767.0 * $cos(ang)));
      cmd.vq = $signed(16'($urandom)) >>> $urandom_range(5);
      cmd.vd = $signed(16'($urandom)) >>> $urandom_range(6);
    end else if (kind < 8) begin
      cmd = pwm_cmd_t'({$urandom, $urandom});
    end else begin
      cmd.vq = edge_value();
      cmd.vd = edge_value();
      cmd.sn = edge_value();
      cmd.cs = edge_value();
    end
    return cmd;
  endfunction

  task automatic report_mismatch(string what, int exp_val, int got_val);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_val,
             got_val);
    mismatch_count++;
  endtask

  // Offer one item, with random idle cycles ahead of it, and wait for its transfer
  task automatic drive_item(pwm_cmd_t cmd, bit typed, pwm_result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_volt_q    <= cmd.vq;
    in_volt_d    <= cmd.vd;
    in_angle_sin <= cmd.sn;
    in_angle_cos <= cmd.cs;
    use_typed    <= typed;
    typed_result <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drive_random(int count);
    for (int i = 0; i < count; i++) drive_item(random_cmd(), 1'b0, NO_RES);
  endtask

  // Stop offering, wait until every expected result has been seen, then settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] per);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= per;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result check, input prediction, period tracking and watchdog
  always @(posedge clk) begin
    pwm_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        report_mismatch("unexpected result (compare_a)", 0, out_compare_a);
      end else begin
        want = expected_duties.pop_front();
        if (out_compare_a !== want.cmp_a) report_mismatch("compare_a", want.cmp_a, out_compare_a);
        if (out_compare_b !== want.cmp_b) report_mismatch("compare_b", want.cmp_b, out_compare_b);
        if (out_compare_c !== want.cmp_c) report_mismatch("compare_c", want.cmp_c, out_compare_c);
        if (out_skip_current !== want.skip)
          report_mismatch("skip_current", want.skip, out_skip_current);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (use_typed) expected_duties.push_back(typed_result);
      else expected_duties.push_back(compute_duty({in_volt_q, in_volt_d, in_angle_sin,
                                                   in_angle_cos}, period_model));
    end
    if (!rst_n) period_model <= 16'd1024;
    else if (cfg_wr_en) period_model <= cfg_wr_data;

    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    tx_idle_pct = 30;
    rx_idle_pct = 78;
    foreach (directed_rows[i])
      drive_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    drain_pipe();

    write_period(16'd65535);
    drive_random(450);
    drain_pipe();

    // roles swapped
    tx_idle_pct = 78;
    rx_idle_pct = 30;
    write_period(16'd1);
    drive_random(150);
    drain_pipe();
    write_period(16'd0);
    drive_random(40);
    drain_pipe();
    write_period(16'($urandom_range(65534, 2)));
    drive_random(350);
    drain_pipe();

    // no idling; a long receiver hold-off mid-stream fills the pipe
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_period(16'd3000);
    drive_random(250);
    hold_reqs <= hold_reqs + 1;
    drive_random(300);
    drain_pipe();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
